FILE: design/ghme_pkg.sv
// ----------------------------------------------------------------------------
// ghme_pkg
// Shared types and constants for the ground height mode estimator.
// ----------------------------------------------------------------------------
package ghme_pkg;

    localparam int BINS_DEF       = 4096;
    localparam int COUNT_BITS_DEF = 16;
    localparam int COORD_W        = 19;
    localparam int OFS_W          = 15;
    localparam int DIST_W         = 18;
    localparam int OUT_CNT_W      = 16;
    localparam int QDEPTH         = 4;

    localparam logic [OFS_W-1:0]  OFS_RESET  = 15'd600;
    localparam logic [DIST_W-1:0] DIST_RESET = 18'd10000;

    localparam logic CFG_RAIL_OFFSET = 1'b0;
    localparam logic CFG_MIN_DIST    = 1'b1;

    // ceil(2^25 / 100); exact quotient for every dividend below 2^18
    localparam logic [18:0] RECIP_100 = 19'd335545;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_SCAN,
        ST_OUT
    } back_state_t;

    // Signed bin of a coordinate, rounding half away from zero.
    // Divide by 100 as a multiply by the reciprocal and a shift by 25.
    function automatic logic signed [12:0] to_bin(input logic signed [COORD_W-1:0] mm);
        logic [COORD_W:0] mag;
        logic [COORD_W:0] num;
        logic [38:0]      prod;
        logic [11:0]      q;
        begin
            mag  = mm[COORD_W-1] ? (COORD_W+1)'(-$signed({mm[COORD_W-1], mm}))
                                 : (COORD_W+1)'({1'b0, mm});
            num  = mag + (COORD_W+1)'(50);
            prod = 39'(num) * 39'(RECIP_100);
            q    = prod[36:25];
            to_bin = mm[COORD_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        end
    endfunction

endpackage

FILE: design/ghme_ram.sv
// ----------------------------------------------------------------------------
// ghme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ghme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

FILE: design/ghme_front.sv
// ----------------------------------------------------------------------------
// ghme_front
// Bins each point, checks range, and pushes it into a short queue.
// ----------------------------------------------------------------------------
module ghme_front #(
    parameter int BINS = 4096
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [ghme_pkg::COORD_W-1:0]     x_mm,
    input  logic signed [ghme_pkg::COORD_W-1:0]     y_mm,
    input  logic signed [ghme_pkg::COORD_W-1:0]     z_mm,
    input  logic                                    last_point,
    output logic                                    q_valid,
    input  logic                                    q_pop,
    output logic [3*$clog2(BINS)+1:0]               q_data
);
    import ghme_pkg::*;

    localparam int AW   = $clog2(BINS);
    localparam int QW   = 3*AW + 2;
    localparam int QAW  = $clog2(QDEPTH);

    logic [QW-1:0]   fifo_reg [QDEPTH];
    logic [QAW-1:0]  wp_reg, rp_reg;
    logic [QAW:0]    cnt_reg;
    logic signed [12:0] bx, by, bz;
    logic            ok;
    logic            push;

    function automatic logic in_rng(input logic signed [12:0] b);
        in_rng = (32'(signed'(b)) >= -(BINS/2)) && (32'(signed'(b)) < (BINS/2));
    endfunction

    function automatic logic [AW-1:0] idx(input logic signed [12:0] b);
        idx = AW'(32'(signed'(b)) + BINS/2);
    endfunction

    always_comb
    begin
        bx = to_bin(x_mm);
        by = to_bin(y_mm);
        bz = to_bin(z_mm);
        ok = in_rng(bx) && in_rng(by) && in_rng(bz);
    end

    assign in_ready = (cnt_reg != (QAW+1)'(QDEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = fifo_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wp_reg] <= {last_point, ok, idx(bx), idx(by), idx(bz)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (q_pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QAW+1)'(push) - (QAW+1)'(q_pop);
        end
    end
endmodule

FILE: design/ghme_back.sv
// ----------------------------------------------------------------------------
// ghme_back
// Histogram update, mode scan, result register and clearing sweep.
// ----------------------------------------------------------------------------
module ghme_back #(
    parameter int BINS       = 4096,
    parameter int COUNT_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    q_valid,
    output logic                                    q_pop,
    input  logic [3*$clog2(BINS)+1:0]               q_data,
    input  logic signed [ghme_pkg::OFS_W-1:0]       rail_offset,
    input  logic [ghme_pkg::DIST_W-1:0]             min_dist,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [ghme_pkg::COORD_W-1:0]     height_mm,
    output logic                                    height_valid,
    output logic [ghme_pkg::OUT_CNT_W-1:0]          z_count,
    output logic [ghme_pkg::OUT_CNT_W-1:0]          y_count,
    output logic [ghme_pkg::OUT_CNT_W-1:0]          x_count,
    output logic signed [ghme_pkg::COORD_W-1:0]     x_mode_mm,
    output logic                                    busy
);
    import ghme_pkg::*;

    localparam int AW = $clog2(BINS);
    localparam int CW = COUNT_BITS;
    localparam logic [CW-1:0] CMAX = '1;

    back_state_t state_reg, state_next;

    // one-point pipeline: stage 1 = read issued, stage 2 = data back, write
    logic          p1_reg, p1_next;
    logic [AW-1:0] a1x_reg, a1y_reg, a1z_reg;
    logic          last1_reg;
    logic [AW:0]   sc_reg, sc_next;      // sweep counter
    logic          sv_reg;               // scan read data valid
    logic [AW-1:0] sa_reg;               // address of scan data
    logic [CW-1:0] bx_reg, by_reg, bz_reg;
    logic [AW-1:0] ix_reg, iz_reg;

    logic          we;
    logic [AW-1:0] raddr_x, raddr_y, raddr_z, waddr_x, waddr_y, waddr_z;
    logic [CW-1:0] wd_x, wd_y, wd_z, rd_x, rd_y, rd_z;
    logic          we_x, we_y, we_z;
    logic          ok_in, last_in;
    logic [AW-1:0] ax_in, ay_in, az_in;

    assign {last_in, ok_in, ax_in, ay_in, az_in} = q_data;

    ghme_ram #(.WIDTH(CW), .DEPTH(BINS)) u_x (.clk, .we(we_x), .waddr(waddr_x),
        .wdata(wd_x), .raddr(raddr_x), .rdata(rd_x));
    ghme_ram #(.WIDTH(CW), .DEPTH(BINS)) u_y (.clk, .we(we_y), .waddr(waddr_y),
        .wdata(wd_y), .raddr(raddr_y), .rdata(rd_y));
    ghme_ram #(.WIDTH(CW), .DEPTH(BINS)) u_z (.clk, .we(we_z), .waddr(waddr_z),
        .wdata(wd_z), .raddr(raddr_z), .rdata(rd_z));

    function automatic logic [OUT_CNT_W-1:0] clip(input logic [CW-1:0] c);
        logic [31:0] w;
        begin
            w = 32'(c);
            clip = (w > 32'hFFFF) ? OUT_CNT_W'(16'hFFFF) : OUT_CNT_W'(w);
        end
    endfunction

    function automatic logic signed [COORD_W-1:0] bin_mm(input logic [AW-1:0] a);
        bin_mm = COORD_W'((32'(a) - BINS/2) * 100);
    endfunction

    // Points: no new point is accepted until the previous one is written back (read, then increment and write).
    always_comb
    begin
        state_next = state_reg;
        p1_next    = 1'b0;
        sc_next    = sc_reg;
        q_pop      = 1'b0;
        raddr_x    = sc_reg[AW-1:0];
        raddr_y    = sc_reg[AW-1:0];
        raddr_z    = sc_reg[AW-1:0];
        we         = 1'b0;
        waddr_x    = sc_reg[AW-1:0];
        waddr_y    = sc_reg[AW-1:0];
        waddr_z    = sc_reg[AW-1:0];
        wd_x       = '0;
        wd_y       = '0;
        wd_z       = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                we      = 1'b1;
                sc_next = sc_reg + 1'b1;
                if (sc_reg == (AW+1)'(BINS-1))
                begin
                    state_next = ST_RUN;
                    sc_next    = '0;
                end
            end
            ST_RUN:
            begin
                raddr_x = ax_in;
                raddr_y = ay_in;
                raddr_z = az_in;
                if (p1_reg)
                begin
                    we      = 1'b1;
                    waddr_x = a1x_reg;
                    waddr_y = a1y_reg;
                    waddr_z = a1z_reg;
                    wd_x    = (rd_x == CMAX) ? rd_x : rd_x + 1'b1;
                    wd_y    = (rd_y == CMAX) ? rd_y : rd_y + 1'b1;
                    wd_z    = (rd_z == CMAX) ? rd_z : rd_z + 1'b1;
                    if (last1_reg)
                    begin
                        state_next = ST_SCAN;
                        sc_next    = '0;
                    end
                end
                else if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (ok_in)
                        p1_next = 1'b1;
                    else if (last_in)
                    begin
                        state_next = ST_SCAN;
                        sc_next    = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                // read address sc, zero behind it (data already captured)
                if (sc_reg != (AW+1)'(BINS))
                    sc_next = sc_reg + 1'b1;
                if (sv_reg)
                begin
                    we      = 1'b1;
                    waddr_x = sa_reg;
                    waddr_y = sa_reg;
                    waddr_z = sa_reg;
                end
                if (sv_reg && sa_reg == AW'(BINS-1))
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid)
                    state_next = ST_RUN;
            end
            default: state_next = ST_CLEAR;
        endcase
        we_x = we;
        we_y = we;
        we_z = we;
    end

    assign busy = (state_reg != ST_RUN) || p1_reg || q_valid;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a1x_reg   <= ax_in;
            a1y_reg   <= ay_in;
            a1z_reg   <= az_in;
            last1_reg <= last_in;
        end
        sa_reg <= sc_reg[AW-1:0];
        if (state_reg == ST_RUN)
        begin
            bx_reg <= '0; by_reg <= '0; bz_reg <= '0;
            ix_reg <= AW'(BINS/2); iz_reg <= AW'(BINS/2);
        end
        else if (state_reg == ST_SCAN && sv_reg)
        begin
            if (rd_x > bx_reg) begin bx_reg <= rd_x; ix_reg <= sa_reg; end
            if (rd_y > by_reg) begin by_reg <= rd_y; end
            if (rd_z > bz_reg) begin bz_reg <= rd_z; iz_reg <= sa_reg; end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            sc_reg    <= '0;
            p1_reg    <= 1'b0;
            sv_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sc_reg    <= sc_next;
            p1_reg    <= p1_next;
            sv_reg    <= (state_reg == ST_SCAN) && (sc_reg != (AW+1)'(BINS));
            if (state_reg == ST_SCAN && state_next == ST_OUT)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    // result register, loaded when the scan completes
    logic signed [COORD_W-1:0] xm;
    logic [CW-1:0] fx, fy, fz;
    logic [AW-1:0] fiz, fix;
    always_comb
    begin
        fx = (rd_x > bx_reg) ? rd_x : bx_reg;
        fy = (rd_y > by_reg) ? rd_y : by_reg;
        fz = (rd_z > bz_reg) ? rd_z : bz_reg;
        fix = (rd_x > bx_reg) ? sa_reg : ix_reg;
        fiz = (rd_z > bz_reg) ? sa_reg : iz_reg;
        xm  = bin_mm(fix);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN && state_next == ST_OUT)
        begin
            height_mm    <= bin_mm(fiz) + COORD_W'(rail_offset);
            x_mode_mm    <= xm;
            z_count      <= clip(fz);
            y_count      <= clip(fy);
            x_count      <= clip(fx);
            height_valid <= (fz != '0) && (fz >= fx) && (fz >= fy) &&
                            ($signed({xm[COORD_W-1], xm}) >= $signed({2'b0, min_dist}));
        end
    end
endmodule

FILE: design/ground_height_mode_estimator.sv
// ----------------------------------------------------------------------------
// ground_height_mode_estimator
// Per-frame histogram modes of x/y/z; reports ground height and validity.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) carries one point per transaction:
//    x_mm, y_mm, z_mm and last_point. A 4-entry queue decouples the binning
//    front end from the histogram back end.
//  - The back end reads the RAM, then does a saturating increment and write
//    back, per point, and takes no new point until that write; the registered
//    RAM read with no forwarding sets this.
//  - On last_point the three histograms are scanned; each entry is zeroed
//    just after it is read, so the next frame starts clean. One result
//    transaction then appears on out_valid/out_ready.
//  - After reset a clearing pass zeros the RAMs; points queue up but
//    are not taken by the back end until it ends.
//  - If the receiver stalls, the result holds; the back end waits, and the
//    queue fills and drops in_ready.
//  - cfg_valid/cfg_ready writes register cfg_index (0 rail offset,
//    1 minimum distance); ready only while the queue is empty and the
//    back end is idle.
// ----------------------------------------------------------------------------
module ground_height_mode_estimator #(
    parameter int BINS       = ghme_pkg::BINS_DEF,
    parameter int COUNT_BITS = ghme_pkg::COUNT_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [0:0]                              cfg_index,
    input  logic [ghme_pkg::DIST_W-1:0]             cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [ghme_pkg::COORD_W-1:0]     x_mm,
    input  logic signed [ghme_pkg::COORD_W-1:0]     y_mm,
    input  logic signed [ghme_pkg::COORD_W-1:0]     z_mm,
    input  logic                                    last_point,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [ghme_pkg::COORD_W-1:0]     height_mm,
    output logic                                    height_valid,
    output logic [ghme_pkg::OUT_CNT_W-1:0]          z_count,
    output logic [ghme_pkg::OUT_CNT_W-1:0]          y_count,
    output logic [ghme_pkg::OUT_CNT_W-1:0]          x_count,
    output logic signed [ghme_pkg::COORD_W-1:0]     x_mode_mm
);
    import ghme_pkg::*;

    localparam int AW = $clog2(BINS);

    logic signed [OFS_W-1:0] ofs_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic                    q_valid, q_pop, busy;
    logic [3*AW+1:0]         q_data;

    // registers never change under a scan; between frames is the user's duty
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofs_reg  <= OFS_RESET;
            dist_reg <= DIST_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RAIL_OFFSET: ofs_reg  <= cfg_data[OFS_W-1:0];
                CFG_MIN_DIST:    dist_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    ghme_front #(.BINS(BINS)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .x_mm, .y_mm, .z_mm, .last_point,
        .q_valid, .q_pop, .q_data
    );

    ghme_back #(.BINS(BINS), .COUNT_BITS(COUNT_BITS)) u_back (
        .clk, .rst_n, .q_valid, .q_pop, .q_data,
        .rail_offset(ofs_reg), .min_dist(dist_reg),
        .out_valid, .out_ready, .height_mm, .height_valid,
        .z_count, .y_count, .x_count, .x_mode_mm, .busy
    );

    // no pop from an empty queue
    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");

    // a valid estimate always carries a nonzero z count
    a_valid_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && height_valid) |-> (z_count != '0)) else $error("valid with zero count");

    // result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(height_mm)))
        else $error("result changed under stall");
endmodule

FILE: sim/ground_height_mode_estimator_test.sv
// ----------------------------------------------------------------------------
// ground_height_mode_estimator_test
// Checks per-frame x/y/z histogram modes, ground height and the validity flag
// against an in-bench predictor, with and without random idling on both channels.
// ----------------------------------------------------------------------------
module ground_height_mode_estimator_test;
    import ghme_pkg::*;

    localparam int NBINS    = 4096;
    localparam int HALF     = NBINS / 2;
    localparam int CMAX     = 65535;
    // scan after each frame plus clearing pass after reset, with margin
    localparam int WD_LIMIT = 40000;

    typedef struct packed {
        logic signed [COORD_W-1:0] height;
        logic                      hvalid;
        logic [OUT_CNT_W-1:0]      zc;
        logic [OUT_CNT_W-1:0]      yc;
        logic [OUT_CNT_W-1:0]      xc;
        logic signed [COORD_W-1:0] xmode;
    } ground_est_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [0:0] cfg_index;
    logic [DIST_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [COORD_W-1:0] x_mm;
    logic signed [COORD_W-1:0] y_mm;
    logic signed [COORD_W-1:0] z_mm;
    logic last_point;
    logic out_valid;
    logic out_ready;
    logic signed [COORD_W-1:0] height_mm;
    logic height_valid;
    logic [OUT_CNT_W-1:0] z_count;
    logic [OUT_CNT_W-1:0] y_count;
    logic [OUT_CNT_W-1:0] x_count;
    logic signed [COORD_W-1:0] x_mode_mm;

    // predictor state
    int unsigned hist_x [NBINS];
    int unsigned hist_y [NBINS];
    int unsigned hist_z [NBINS];
    int rail_ofs;
    int min_dist;

    ground_est_t pending_estimates [$];
    int  mismatches;
    int  frames_seen;
    int  points_sent;
    int  idle_cnt;
    int  stall_left;
    bit  no_idle;

    ground_height_mode_estimator uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .x_mm(x_mm), .y_mm(y_mm), .z_mm(z_mm), .last_point(last_point),
        .out_valid(out_valid), .out_ready(out_ready),
        .height_mm(height_mm), .height_valid(height_valid),
        .z_count(z_count), .y_count(y_count), .x_count(x_count),
        .x_mode_mm(x_mode_mm)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // round half away from zero to 100 mm bins
    function automatic int bin_of(input int mm);
        if (mm >= 0)
            return (mm + 50) / 100;
        return -((-mm + 50) / 100);
    endfunction

    function automatic void mode_of(input int unsigned h [NBINS], output int b,
                                    output int unsigned c);
        b = 0;
        c = 0;
        for (int i = 0; i < NBINS; i++)
        begin
            if (h[i] > c)
            begin
                c = h[i];
                b = i - HALF;
            end
        end
    endfunction

    // bin the point; on last_point, queue the frame estimate and clear
    task automatic predict_point(input int x, input int y, input int z, input bit last);
        int bx, by, bz, mz, my, mx;
        int unsigned cz, cy, cx;
        ground_est_t e;
        bx = bin_of(x);
        by = bin_of(y);
        bz = bin_of(z);
        if (bx >= -HALF && bx < HALF && by >= -HALF && by < HALF && bz >= -HALF && bz < HALF)
        begin
            if (hist_x[bx + HALF] < CMAX) hist_x[bx + HALF]++;
            if (hist_y[by + HALF] < CMAX) hist_y[by + HALF]++;
            if (hist_z[bz + HALF] < CMAX) hist_z[bz + HALF]++;
        end
        if (!last)
            return;
        mode_of(hist_z, mz, cz);
        mode_of(hist_y, my, cy);
        mode_of(hist_x, mx, cx);
        e.height = COORD_W'(mz * 100 + rail_ofs);
        e.hvalid = (cz != 0) && (cz >= cx) && (cz >= cy) && (mx * 100 >= min_dist);
        e.zc     = cz[15:0];
        e.yc     = cy[15:0];
        e.xc     = cx[15:0];
        e.xmode  = COORD_W'(mx * 100);
        pending_estimates = {pending_estimates, e};
        for (int i = 0; i < NBINS; i++)
        begin
            hist_x[i] = 0;
            hist_y[i] = 0;
            hist_z[i] = 0;
        end
    endtask

    // one point transaction, sometimes with a random idle burst ahead of it
    task automatic send_point(input int x, input int y, input int z, input bit last);
        logic signed [COORD_W-1:0] xs, ys, zs;
        xs = COORD_W'(x);
        ys = COORD_W'(y);
        zs = COORD_W'(z);
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        x_mm       <= xs;
        y_mm       <= ys;
        z_mm       <= zs;
        last_point <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_point(xs, ys, zs, last);
        points_sent++;
    endtask

    // drain, let the scan finish, then write a register
    task automatic write_reg(input logic [0:0] idx, input int val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= DIST_W'(val);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_RAIL_OFFSET)
            rail_ofs = $signed(OFS_W'(val));
        else
            min_dist = val & ((1 << DIST_W) - 1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic int rand_coord();
        return $urandom_range(0, 409550) - 204800;
    endfunction

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------
    task automatic test_extremes();
        // coordinate extremes; 204750 rounds out of range, point is dropped
        send_point(-204800, -204800, -204800, 1'b0);
        send_point(204749, 204749, 204749, 1'b0);
        send_point(204750, 0, 0, 1'b0);
        send_point(0, 204750, 0, 1'b0);
        send_point(0, 0, 204750, 1'b0);
        send_point(-50, 50, -149, 1'b0);
        send_point(-51, 149, 150, 1'b1);
        // empty frame
        send_point(204750, 204750, 204750, 1'b1);
        // out-of-range last point ends a frame with one point in it
        send_point(30000, 5, 7, 1'b0);
        send_point(0, 0, 204750, 1'b1);
        // ties: lowest bin wins
        send_point(20000, 300, -200, 1'b0);
        send_point(15000, -300, 200, 1'b0);
        send_point(15000, -300, 200, 1'b0);
        send_point(20000, 300, -200, 1'b1);
    endtask

    task automatic test_valid_flag();
        // z dominant, x far: valid; then x below the limit and z no longer dominant
        for (int i = 0; i < 6; i++)
            send_point(12000 + i * 100, i * 100, 500, i == 5);
        for (int i = 0; i < 6; i++)
            send_point(9000, -1000, 500 + i * 100, i == 5);
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_RAIL_OFFSET, -10000);
        write_reg(CFG_MIN_DIST, 0);
        send_point(-3000, 0, -204800, 1'b1);
        write_reg(CFG_RAIL_OFFSET, 10000);
        write_reg(CFG_MIN_DIST, 200000);
        send_point(204749, 0, 204749, 1'b1);
        write_reg(CFG_MIN_DIST, 262143);
        send_point(1000, 1000, 1000, 1'b1);
        write_reg(CFG_RAIL_OFFSET, 16383);
        send_point(1000, 1000, 1000, 1'b1);
    endtask

    // clustered frames so modes and the flag move; some uniform noise
    task automatic test_random_frames(input int n_points);
        int sent, len, cx, cy, cz;
        sent = 0;
        while (sent < n_points)
        begin
            len = $urandom_range(1, 40);
            cx  = rand_coord();
            cy  = rand_coord();
            cz  = rand_coord();
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_point(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
                else
                    send_point(cx + $urandom_range(0, 400) - 200,
                               cy + $urandom_range(0, 600) - 300,
                               cz + $urandom_range(0, 300) - 150, i == len - 1);
            end
            sent += len;
            if (!no_idle && $urandom_range(0, 7) == 0)
                write_reg(1'($urandom_range(0, 1)),
                          int'($urandom_range(0, 1) ? $urandom_range(0, 200000)
                                                    : $urandom_range(0, 20000) - 10000));
        end
    endtask

    // random receiver stall bursts
    always @(posedge clk)
    begin
        if (no_idle)
        begin
            stall_left = 0;
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= (stall_left == 0);
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 14);
            out_ready <= 1'b0;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            ground_est_t got, want;
            got = {height_mm, height_valid, z_count, y_count, x_count, x_mode_mm};
            if (pending_estimates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = pending_estimates.pop_front();
                frames_seen++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("frame %0d: expected %p, got %p", frames_seen, want, got);
                end
            end
        end
    end

    // watchdog: cycles with no transaction at all
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > WD_LIMIT)
        begin
            $display("watchdog timeout");
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; x_mm = '0; y_mm = '0; z_mm = '0; last_point = 1'b0;
        out_ready = 1'b1; stall_left = 0; no_idle = 1'b0;
        mismatches = 0; frames_seen = 0; points_sent = 0; idle_cnt = 0;
        rail_ofs = 600; min_dist = 10000;
        for (int i = 0; i < NBINS; i++)
        begin
            hist_x[i] = 0; hist_y[i] = 0; hist_z[i] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_valid_flag();
        test_config_extremes();
        write_reg(CFG_RAIL_OFFSET, 600);
        write_reg(CFG_MIN_DIST, 10000);
        test_random_frames(900);
        wait_drained();   // sender holds until every estimate is back
        no_idle = 1'b1;
        test_random_frames(250);

        wait_drained();
        repeat (NBINS + 50) @(posedge clk);
        if (pending_estimates.size() != 0)
            mismatches++;
        $display("%0d points in %0d frames checked, rail offset and distance limit swept",
                 points_sent, frames_seen);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
